// ----- sv/assert_macros.svh -----
// Assertion macros for the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/sgr_pkg.sv -----
// Types, constants and the colour palette of the SGR colour parser.
package sgr_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_NUM   = 2'd2
    } mode_t;

    localparam logic [7:0] CHAR_ESC      = 8'd27;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_SEMI     = 8'h3B;
    localparam logic [7:0] CHAR_M        = 8'h6D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;

    localparam logic [6:0] BRIGHT_OFFSET = 7'd60;
    localparam logic [6:0] FG_DEFAULT    = 7'd39;
    localparam logic [6:0] BG_DEFAULT    = 7'd49;
    localparam logic [23:0] RGB_WHITE    = 24'hFFFFFF;

    typedef struct packed {
        logic       is_plain;
        logic [7:0] out_byte;
        logic [6:0] fg_code;
        logic [6:0] bg_code;
    } result_t;

    // Rows: normal foreground, normal background, bright foreground, bright background.
    // Each entry holds red in bits 7:0, green in 15:8 and blue in 23:16.
    localparam logic [23:0] PALETTE [4][8] = '{
        '{24'h000000, 24'h0000BB, 24'h008C00, 24'h00BBBB,
          24'hBB0000, 24'hBB00BB, 24'hB48C00, 24'hE5E5E5},
        '{24'h000000, 24'h0000BB, 24'h00BB00, 24'h0082FF,
          24'hBB0000, 24'hBB00BB, 24'hBBBB00, 24'hE5E5E5},
        '{24'h555555, 24'h0000FF, 24'h00B400, 24'h0082FF,
          24'hFF7F00, 24'hF500F5, 24'hF5F500, 24'hFFFFFF},
        '{24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
          24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF}
    };

    function automatic logic [23:0] code_rgb(input logic [6:0] code);
        logic [23:0] rgb;
        case (code) inside
            [7'd30:7'd37]:   rgb = PALETTE[0][code[2:0] - 3'd6];
            [7'd40:7'd47]:   rgb = PALETTE[1][code[2:0]];
            [7'd90:7'd97]:   rgb = PALETTE[2][code[2:0] - 3'd2];
            [7'd100:7'd107]: rgb = PALETTE[3][code[2:0] - 3'd4];
            7'd49:           rgb = RGB_WHITE;
            default:         rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

// ----- sv/ansi_sgr_color_parser_core.sv -----
// Byte filter that strips ANSI control sequences and tracks the SGR colour codes.
// The result of an accepted byte is registered in the output register, or in the skid register.
// Throughput: one byte per cycle while in_stall is low; the parser state updates with the result.
// A skid register holds one result while the output is stalled, so input stall rises
// only when both the output register and the skid register are full.
// Reset (asynchronous, active low) returns to plain text with colours 39 and 49.
module ansi_sgr_color_parser_core #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_plain,
    output logic [7:0]  out_byte,
    output logic [6:0]  fg_code,
    output logic [6:0]  bg_code,
    output logic [23:0] fg_rgb,
    output logic [23:0] bg_rgb
);

    localparam logic [NUMBER_WIDTH-1:0] ACC_MAX = {NUMBER_WIDTH{1'b1}};

    sgr_pkg::mode_t          mode_reg, mode_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic [1:0]              count_reg, count_next;
    logic [NUMBER_WIDTH-1:0] first_reg, first_next;
    logic                    second_one_reg, second_one_next;
    logic [6:0]              fg_reg, fg_next;
    logic [6:0]              bg_reg, bg_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    sgr_pkg::result_t        out_data_reg, skid_data_reg;

    logic                    accept;
    logic                    out_fire;
    logic                    plain;
    logic [NUMBER_WIDTH+3:0] acc_product;
    logic [1:0]              count_closed;
    logic [NUMBER_WIDTH-1:0] first_closed;
    logic                    second_one_closed;
    logic [NUMBER_WIDTH:0]   colour;
    sgr_pkg::result_t        result;

    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // Ten times the accumulator plus the new digit, wide enough never to wrap.
    assign acc_product = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                       + {{NUMBER_WIDTH{1'b0}}, text_byte[3:0]};

    always_comb
    begin
        first_closed      = first_reg;
        second_one_closed = second_one_reg;
        if (count_reg == 2'd0)
        begin
            first_closed = acc_reg;
        end
        else if (count_reg == 2'd1)
        begin
            second_one_closed = (acc_reg == {{(NUMBER_WIDTH-1){1'b0}}, 1'b1});
        end
        count_closed = (count_reg == 2'd3) ? count_reg : count_reg + 2'd1;

        colour = {1'b0, first_closed};
        if (count_closed == 2'd2 && second_one_closed)
        begin
            colour = colour + {{(NUMBER_WIDTH-6){1'b0}}, sgr_pkg::BRIGHT_OFFSET};
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        second_one_next = second_one_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        plain           = 1'b0;
        case (mode_reg)
            sgr_pkg::MODE_ESC:
            begin
                if (text_byte == sgr_pkg::CHAR_LBRACKET)
                begin
                    mode_next       = sgr_pkg::MODE_NUM;
                    acc_next        = '0;
                    count_next      = 2'd0;
                    first_next      = '0;
                    second_one_next = 1'b0;
                end
                else
                begin
                    mode_next = sgr_pkg::MODE_PLAIN;
                    plain     = 1'b1;
                end
            end
            sgr_pkg::MODE_NUM:
            begin
                if (text_byte >= sgr_pkg::CHAR_ZERO && text_byte <= sgr_pkg::CHAR_NINE)
                begin
                    if (acc_product > {4'b0000, ACC_MAX})
                    begin
                        acc_next = ACC_MAX;
                    end
                    else
                    begin
                        acc_next = acc_product[NUMBER_WIDTH-1:0];
                    end
                end
                else
                begin
                    acc_next        = '0;
                    count_next      = count_closed;
                    first_next      = first_closed;
                    second_one_next = second_one_closed;
                    if (text_byte != sgr_pkg::CHAR_SEMI)
                    begin
                        mode_next = sgr_pkg::MODE_PLAIN;
                        if (text_byte == sgr_pkg::CHAR_M)
                        begin
                            if (colour == '0)
                            begin
                                fg_next = sgr_pkg::FG_DEFAULT;
                                bg_next = sgr_pkg::BG_DEFAULT;
                            end
                            else if ((colour >= 30 && colour <= 37) || colour == 39
                                     || (colour >= 90 && colour <= 97))
                            begin
                                fg_next = colour[6:0];
                            end
                            else if ((colour >= 40 && colour <= 47) || colour == 49
                                     || (colour >= 100 && colour <= 107))
                            begin
                                bg_next = colour[6:0];
                            end
                        end
                    end
                end
            end
            default:
            begin
                if (text_byte == sgr_pkg::CHAR_ESC)
                begin
                    mode_next = sgr_pkg::MODE_ESC;
                end
                else
                begin
                    mode_next = sgr_pkg::MODE_PLAIN;
                    plain     = 1'b1;
                end
            end
        endcase

        result.is_plain = plain;
        result.out_byte = text_byte;
        result.fg_code  = fg_next;
        result.bg_code  = bg_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (accept)
        begin
            if (out_fire || !out_valid_reg)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sgr_pkg::MODE_PLAIN;
            acc_reg        <= '0;
            count_reg      <= 2'd0;
            first_reg      <= '0;
            second_one_reg <= 1'b0;
            fg_reg         <= sgr_pkg::FG_DEFAULT;
            bg_reg         <= sgr_pkg::BG_DEFAULT;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg       <= mode_next;
                acc_reg        <= acc_next;
                count_reg      <= count_next;
                first_reg      <= first_next;
                second_one_reg <= second_one_next;
                fg_reg         <= fg_next;
                bg_reg         <= bg_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (out_fire || !out_valid_reg))
        begin
            out_data_reg <= result;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (accept && out_valid_reg && !out_fire)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_plain  = out_data_reg.is_plain;
    assign out_byte  = out_data_reg.out_byte;
    assign fg_code   = out_data_reg.fg_code;
    assign bg_code   = out_data_reg.bg_code;
    assign fg_rgb    = sgr_pkg::code_rgb(out_data_reg.fg_code);
    assign bg_rgb    = sgr_pkg::code_rgb(out_data_reg.bg_code);

endmodule

// ----- sv/sgr_checker.sv -----
// Port-level checks for the SGR colour parser and the bind that attaches them.
`include "assert_macros.svh"

module sgr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  text_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic        is_plain,
    input logic [7:0]  out_byte,
    input logic [6:0]  fg_code,
    input logic [6:0]  bg_code,
    input logic [23:0] fg_rgb,
    input logic [23:0] bg_rgb
);

    logic fg_legal;
    logic bg_legal;

    assign fg_legal = (fg_code >= 7'd30 && fg_code <= 7'd37) || fg_code == 7'd39
                   || (fg_code >= 7'd90 && fg_code <= 7'd97);
    assign bg_legal = (bg_code >= 7'd40 && bg_code <= 7'd47) || bg_code == 7'd49
                   || (bg_code >= 7'd100 && bg_code <= 7'd107);

    // The colour values always follow the codes shown in the same beat.
    `ASSERT_SAME(rgb_matches_code, clk, rst_n, out_valid,
                 fg_rgb == sgr_pkg::code_rgb(fg_code) && bg_rgb == sgr_pkg::code_rgb(bg_code))

    // Only codes that select a colour of the proper plane ever reach the output.
    `ASSERT_SAME(codes_legal, clk, rst_n, out_valid, fg_legal && bg_legal)

    // Every accepted byte leaves a beat waiting on the output in the next cycle.
    `ASSERT_NEXT(accept_gives_beat, clk, rst_n, in_valid && !in_stall, out_valid)

    // A stalled result beat holds.
    `ASSERT_NEXT(stalled_beat_holds, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(out_byte) && $stable(is_plain) && $stable(fg_code)
                 && $stable(bg_code))

    logic unused_payload;
    assign unused_payload = ^text_byte;

endmodule

bind ansi_sgr_color_parser_core sgr_checker u_sgr_checker (.*);
